@@ hdl/ppts_pkg.sv @@
// shared types, opcodes and helpers for the periodic priority task scheduler
// no dependencies; imported by ppts_ctrl, ppts_dp and the core top level
package ppts_pkg;

   localparam int PRIO_W   = 8;
   localparam int PERIOD_W = 16;
   localparam int SEL_W    = 5;
   localparam int SLOTID_W = 6;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_TICK     = 2'd1,
      OP_RUN      = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [SLOTID_W-1:0] slot_id;
      logic                handler_valid;
      logic [PRIO_W-1:0]   task_priority;
      logic [PERIOD_W-1:0] task_period;
   } req_type;

   typedef struct packed {
      logic             register_ok;
      logic             task_found;
      logic [SEL_W-1:0] selected_task;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic reduce;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
   } dp_status_type;

   // one node of the selection tree
   typedef struct packed {
      logic              valid;
      logic [PRIO_W-1:0] prio;
      logic [SEL_W-1:0]  idx;
   } cand_type;

   // left node holds the lower indices, so it wins ties
   function automatic cand_type cand_pick(cand_type left, cand_type right);
      cand_type pick;
      pick = left;
      if (right.valid && (!left.valid || (right.prio > left.prio))) begin
         pick = right;
      end
      return pick;
   endfunction

endpackage

@@ hdl/ppts_ctrl.sv @@
// control state machine of the task scheduler: sequences capture, execute,
// tree reduction and result hand-off; uses ppts_pkg
module ppts_ctrl #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  ppts_pkg::dp_status_type status,
   output ppts_pkg::dp_cmd_type    cmd
);
   import ppts_pkg::*;

   localparam int LEVELS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 0;
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      cmd       = '0;
      out_free  = !rsp_valid_ff || !rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            lvl_in   = '0;
            if ((status.op == OP_RUN) && (LEVELS > 0)) begin
               state_in = ST_REDUCE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            lvl_in     = LVL_W'(lvl_ff + 1'b1);
            if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/ppts_dp.sv @@
// datapath of the task scheduler: slot tables, tick update, register write,
// registered selection tree and result register; uses ppts_pkg
module ppts_dp #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppts_pkg::dp_cmd_type    cmd,
   input  ppts_pkg::req_type       req_word,
   output ppts_pkg::dp_status_type status,
   output ppts_pkg::rsp_type       rsp_word
);
   import ppts_pkg::*;

   localparam int LEVELS    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 0;
   localparam int TREE_SIZE = 1 << LEVELS;
   localparam int HALF      = TREE_SIZE / 2;

   req_type             req_ff;
   op_type              op;
   logic                reg_ok;

   logic [PERIOD_W-1:0] period_ff [SLOT_COUNT];
   logic [PERIOD_W-1:0] period_in [SLOT_COUNT];
   logic [PERIOD_W-1:0] count_ff  [SLOT_COUNT];
   logic [PERIOD_W-1:0] count_in  [SLOT_COUNT];
   logic [PERIOD_W-1:0] count_inc [SLOT_COUNT];
   logic [PRIO_W-1:0]   prio_ff   [SLOT_COUNT];
   logic [PRIO_W-1:0]   prio_in   [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] ready_ff, ready_in;
   logic [SLOT_COUNT-1:0] used_ff, used_in;

   cand_type            leaf     [TREE_SIZE];
   cand_type            cand_ff  [TREE_SIZE];
   cand_type            cand_in  [TREE_SIZE];
   rsp_type             rsp_ff, rsp_in;

   assign op        = op_type'(req_ff.func);
   assign status.op = op;
   assign reg_ok    = (req_ff.slot_id < SLOTID_W'(SLOT_COUNT)) && req_ff.handler_valid
                      && (req_ff.task_period != '0);

   // leaves past the last slot never win
   for (genvar g = 0; g < TREE_SIZE; g++) begin : g_leaf
      if (g < SLOT_COUNT) begin : g_slot
         assign leaf[g].valid = used_ff[g] && ready_ff[g];
         assign leaf[g].prio  = prio_ff[g];
         assign leaf[g].idx   = SEL_W'(g);
      end else begin : g_pad
         assign leaf[g] = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         count_inc[i] = count_ff[i] + 16'd1;
      end
   end

   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      prio_in   = prio_ff;
      ready_in  = ready_ff;
      used_in   = used_ff;
      cand_in   = cand_ff;
      rsp_in    = rsp_ff;

      if (cmd.exec && (op == OP_REGISTER) && reg_ok) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (req_ff.slot_id == SLOTID_W'(i)) begin
               period_in[i] = req_ff.task_period;
               prio_in[i]   = req_ff.task_priority;
               count_in[i]  = '0;
               ready_in[i]  = 1'b0;
               used_in[i]   = 1'b1;
            end
         end
      end

      if (cmd.exec && (op == OP_TICK)) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (used_ff[i]) begin
               if (count_inc[i] >= period_ff[i]) begin
                  count_in[i] = '0;
                  ready_in[i] = 1'b1;
               end else begin
                  count_in[i] = count_inc[i];
               end
            end
         end
      end

      // one tree level per cycle, folded in place toward node zero
      if (cmd.exec && (op == OP_RUN)) begin
         cand_in = leaf;
      end else if (cmd.reduce) begin
         for (int i = 0; i < HALF; i++) begin
            cand_in[i] = cand_pick(cand_ff[2*i], cand_ff[2*i+1]);
         end
      end

      if (cmd.emit) begin
         rsp_in.register_ok   = (op == OP_REGISTER) && reg_ok;
         rsp_in.task_found    = (op == OP_RUN) && cand_ff[0].valid;
         rsp_in.selected_task = rsp_in.task_found ? cand_ff[0].idx : '0;
         if (rsp_in.task_found) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (cand_ff[0].idx == SEL_W'(i)) begin
                  ready_in[i] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
         used_ff  <= '0;
      end else begin
         ready_ff <= ready_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      period_ff <= period_in;
      count_ff  <= count_in;
      prio_ff   <= prio_in;
      cand_ff   <= cand_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

@@ hdl/periodic_priority_task_scheduler_core.sv @@
// top level of the periodic priority task scheduler
// instantiates ppts_ctrl and ppts_dp; uses ppts_pkg
//
// usage
// - req channel: req_valid / req_stall / req_word; a word is taken at a rising edge
//   with req_valid high and req_stall low; func selects register, tick or run
// - rsp channel: rsp_valid / rsp_stall / rsp_word; exactly one result word per
//   request word, in order
// - register, tick and unused func load their result word after the execute state;
//   run first passes the levels of the priority tree, clog2(SLOT_COUNT) of them,
//   before its result is loaded; loading waits while the previous result is stalled
// - one word at a time; the next word is taken only after the previous result is
//   loaded into the output register
// - the run search goes through a registered compare tree, one level a cycle
// - the output register parts the two sides: a waiting result does not block the
//   next request; only a second finished result waits for the first to drain
// - reset clears all used and ready flags and the handshake state
module periodic_priority_task_scheduler_core #(
   parameter int SLOT_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppts_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppts_pkg::rsp_type rsp_word
);
   import ppts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing: idle, execute, tree levels, hand-off
   ppts_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // slot tables, tick logic, selection tree and result register
   ppts_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .status   (status),
      .rsp_word (rsp_word)
   );

   // one word in flight: an accepted request blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another word in flight");

   // a result is either a register answer or a run answer, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.register_ok && rsp_word.task_found))
      else $error("register_ok and task_found both set");

   // no selection reported without a found task
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.task_found) |-> (rsp_word.selected_task == '0))
      else $error("selected_task nonzero without task_found");

   // a selected slot is always a real slot
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.task_found)
         |-> (32'(rsp_word.selected_task) < 32'(SLOT_COUNT)))
      else $error("selected_task beyond slot count");

endmodule
